>>> sv/mwm_pkg.sv
// Shared types and constants of the minhash word-minimum block.
package mwm_pkg;

  // Item and register widths
  localparam int CH_W     = 8;
  localparam int HASH_W   = 32;
  localparam int COEF_W   = 31;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // djb2 seed and shift (hash*33 = (hash << 5) + hash)
  localparam logic [HASH_W-1:0] HASH_SEED  = 32'd5381;
  localparam int                HASH_SHIFT = 5;

  // Word separators
  localparam logic [CH_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;

  // Register reset values
  localparam logic [COEF_W-1:0] COEF_A_RST   = 31'd1;
  localparam logic [COEF_W-1:0] OFFSET_B_RST = 31'd0;
  localparam logic [HASH_W-1:0] MODULUS_RST  = 32'd99839;

  // Shared-unit step counts
  localparam int MUL_STEPS = COEF_W;
  localparam int DIV_STEPS = HASH_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Input item modes
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_EOD  = 1'b1;

  // Register map, word index on paddr[3:2]
  typedef enum logic [1:0] {
    REG_COEF_A   = 2'd0,
    REG_OFFSET_B = 2'd1,
    REG_MODULUS  = 2'd2
  } reg_idx_e;

endpackage

>>> sv/mwm_if.sv
// Request channels of the minhash word-minimum block: document bytes in, minimum out.
interface mwm_in_if import mwm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            mode;
  logic [CH_W-1:0] ch;

  modport source (output valid, output mode, output ch, input ready);
  modport sink   (input valid, input mode, input ch, output ready);
endinterface

interface mwm_out_if import mwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] min_hash;
  logic              empty_doc;

  modport source (output valid, output min_hash, output empty_doc, input ready);
  modport sink   (input valid, input min_hash, input empty_doc, output ready);
endinterface

>>> sv/minhash_word_min.sv
// Minhash word minimum: per-document minimum of a universal hash over djb2 word hashes.
//
// Bytes arrive one request at a time; space and newline close a word. A byte that
// extends a word is hashed without leaving idle. Closing a word runs the mapping
// ((coef_a*hash + offset_b) mod 2^32) mod modulus through one shared 34-bit adder:
// 31 shift-add multiply steps, one offset add, 32 restoring remainder steps (left
// out when modulus is zero) and one compare against the running minimum; the
// input stays stalled from the closing request until the compare is done. An
// end-of-document request also holds it in an emit state that loads the result
// register; the next document's bytes are taken while that result waits to be drained.
// Registers sit at byte addresses 0 (coef_a), 4 (offset_b) and 8 (modulus); the user
// must write them only while the block is idle, which the block itself does not enforce.
module minhash_word_min import mwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  mwm_in_if.sink             in_i,
  mwm_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADDB,
    S_DIV,
    S_CMP,
    S_EMIT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [COEF_W-1:0] coef_a_q;
  logic [COEF_W-1:0] offset_b_q;
  logic [HASH_W-1:0] modulus_q;

  // Document state
  logic [HASH_W-1:0] word_hash_q;
  logic              word_open_q;
  logic [HASH_W-1:0] min_value_q;
  logic              have_min_q;
  logic              eod_q;
  logic [CNT_W-1:0]  cnt_q;

  // Datapath of the shared unit
  logic [HASH_W-1:0] acc_q;
  logic [HASH_W-1:0] mcand_q;
  logic [COEF_W-1:0] mplier_q;
  logic [HASH_W-1:0] rem_q;

  // Result register
  logic              out_valid_q;
  logic [HASH_W-1:0] out_min_hash_q;
  logic              out_empty_doc_q;

  logic              in_acc;
  logic              is_sep;
  logic [HASH_W-1:0] hash_next;
  logic              out_free;
  logic              cfg_wr;

  logic [HASH_W:0]   alu_a;
  logic [HASH_W:0]   alu_b;
  logic              alu_cin;
  logic [HASH_W+1:0] alu_sum;
  logic              alu_ge;
  logic [HASH_W-1:0] rem_next;

  // Handshake and APB decode
  assign in_i.ready      = (state_q == S_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign is_sep          = (in_i.ch == CH_SPACE) || (in_i.ch == CH_NEWLINE);
  assign out_free        = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.min_hash  = out_min_hash_q;
  assign out_o.empty_doc = out_empty_doc_q;
  assign pready          = 1'b1;
  assign cfg_wr          = psel && penable && pwrite;

  // djb2 step: hash*33 plus the sign-extended byte
  assign hash_next = (word_hash_q << HASH_SHIFT) + word_hash_q
                   + {{(HASH_W-CH_W){in_i.ch[CH_W-1]}}, in_i.ch};

  // Select operands of the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (state_q)
      S_MUL: begin
        alu_a = {1'b0, acc_q};
        alu_b = mplier_q[0] ? {1'b0, mcand_q} : '0;
      end
      S_ADDB: begin
        alu_a = {1'b0, acc_q};
        alu_b = {2'b00, offset_b_q};
      end
      S_DIV: begin
        alu_a   = {rem_q, mcand_q[HASH_W-1]};
        alu_b   = ~{1'b0, modulus_q};
        alu_cin = 1'b1;
      end
      S_CMP: begin
        alu_a   = {1'b0, acc_q};
        alu_b   = ~{1'b0, min_value_q};
        alu_cin = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
      end
    endcase
  end

  assign alu_sum  = {1'b0, alu_a} + {1'b0, alu_b} + {{(HASH_W+1){1'b0}}, alu_cin};
  assign alu_ge   = alu_sum[HASH_W+1];
  assign rem_next = alu_ge ? alu_sum[HASH_W-1:0] : alu_a[HASH_W-1:0];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q   <= COEF_A_RST;
      offset_b_q <= OFFSET_B_RST;
      modulus_q  <= MODULUS_RST;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_COEF_A:   coef_a_q   <= pwdata[COEF_W-1:0];
        REG_OFFSET_B: offset_b_q <= pwdata[COEF_W-1:0];
        REG_MODULUS:  modulus_q  <= pwdata[HASH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_COEF_A:   prdata = {1'b0, coef_a_q};
      REG_OFFSET_B: prdata = {1'b0, offset_b_q};
      REG_MODULUS:  prdata = modulus_q;
      default:      prdata = '0;
    endcase
  end

  // Advance the sequencer, document state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      word_hash_q     <= HASH_SEED;
      word_open_q     <= 1'b0;
      min_value_q     <= '0;
      have_min_q      <= 1'b0;
      eod_q           <= 1'b0;
      cnt_q           <= '0;
      out_valid_q     <= 1'b0;
      out_min_hash_q  <= '0;
      out_empty_doc_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cnt_q <= '0;
            eod_q <= (in_i.mode == MODE_EOD);
            if (in_i.mode == MODE_EOD) begin
              state_q <= word_open_q ? S_MUL : S_EMIT;
            end else if (is_sep) begin
              if (word_open_q) begin
                state_q <= S_MUL;
              end
            end else begin
              word_hash_q <= hash_next;
              word_open_q <= 1'b1;
            end
          end
        end
        S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
            state_q <= S_ADDB;
          end
        end
        S_ADDB: begin
          cnt_q   <= '0;
          state_q <= (modulus_q == '0) ? S_CMP : S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          // keep the smaller mapped hash, then reopen the word
          if (!have_min_q || !alu_ge) begin
            min_value_q <= acc_q;
            have_min_q  <= 1'b1;
          end
          word_hash_q <= HASH_SEED;
          word_open_q <= 1'b0;
          state_q     <= eod_q ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            out_min_hash_q  <= have_min_q ? min_value_q : '0;
            out_empty_doc_q <= !have_min_q;
            word_hash_q     <= HASH_SEED;
            word_open_q     <= 1'b0;
            min_value_q     <= '0;
            have_min_q      <= 1'b0;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Hold operands of the shared unit
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        acc_q    <= '0;
        mcand_q  <= word_hash_q;
        mplier_q <= coef_a_q;
        rem_q    <= '0;
      end
      S_MUL: begin
        acc_q    <= alu_sum[HASH_W-1:0];
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
      S_ADDB: begin
        acc_q   <= alu_sum[HASH_W-1:0];
        mcand_q <= alu_sum[HASH_W-1:0];
        rem_q   <= '0;
      end
      S_DIV: begin
        rem_q   <= rem_next;
        mcand_q <= mcand_q << 1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          acc_q <= rem_next;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/mwm_chk.sv
// Port-level checker of the minhash word-minimum block and its bind.
module mwm_chk import mwm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_mode_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [HASH_W-1:0]  out_min_hash_i,
  input logic               out_empty_doc_i,
  input logic               psel_i,
  input logic               penable_i,
  input logic               pwrite_i,
  input logic [PADDR_W-1:0] paddr_i,
  input logic [PDATA_W-1:0] pwdata_i
);

  logic [HASH_W-1:0] modulus_q;

  // Track the modulus register from the write requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
    end else if (psel_i && penable_i && pwrite_i
                 && reg_idx_e'(paddr_i[3:2]) == REG_MODULUS) begin
      modulus_q <= pwdata_i;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_min_hash_i)
      && $stable(out_empty_doc_i))
    else $error("result changed while stalled");

  // An empty document reports zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_doc_i |-> out_min_hash_i == '0)
    else $error("empty document with nonzero minimum");

  // End of document always takes the sequencer out of idle
  a_eod_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_mode_i == MODE_EOD |=> !in_ready_i)
    else $error("input ready right after end of document");

  // The minimum stays below a nonzero modulus
  a_min_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_empty_doc_i && modulus_q != '0 |-> out_min_hash_i < modulus_q)
    else $error("minimum not reduced by modulus");

endmodule

bind minhash_word_min mwm_chk u_mwm_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_mode_i       (in_i.mode),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_min_hash_i  (out_o.min_hash),
  .out_empty_doc_i (out_o.empty_doc),
  .psel_i          (psel),
  .penable_i       (penable),
  .pwrite_i        (pwrite),
  .paddr_i         (paddr),
  .pwdata_i        (pwdata)
);

>>> tb/tb_top.sv
// Testbench of the minhash word-minimum block: byte requests in, per-document minimum checked.
module tb_top;
  import mwm_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 3;
  localparam int MAP_LATENCY  = 100;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT_A    = 20;
  localparam int HOLD_AT_B    = 60;
  localparam int ITEM_TARGET  = 1700;
  localparam int CALM_ITEMS   = 150;
  localparam int PHASE_ITEMS  = 200;
  localparam logic [HASH_W-1:0] DJB_MULT = 32'd33;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] ch;
  } doc_byte_t;

  typedef struct packed {
    logic [HASH_W-1:0] min_hash;
    logic              empty_doc;
  } doc_min_t;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mwm_in_if  byte_req ();
  mwm_out_if min_req ();

  minhash_word_min i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (byte_req),
    .out_o   (min_req),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Byte requests waiting to be sent and document minima waiting to arrive
  doc_byte_t byte_queue[$];
  doc_min_t  min_expected[$];

  int     errors       = 0;
  int     mins_seen    = 0;
  int     items_queued = 0;
  int     send_gap     = 0;
  int     recv_hold    = 0;
  longint cycles       = 0;
  bit     calm         = 1'b0;

  // Mirror of the configuration registers
  logic [COEF_W-1:0] cfg_coef_a   = COEF_A_RST;
  logic [COEF_W-1:0] cfg_offset_b = OFFSET_B_RST;
  logic [HASH_W-1:0] cfg_modulus  = MODULUS_RST;

  // Mirror of the document state
  logic [HASH_W-1:0] run_hash     = HASH_SEED;
  bit                in_word      = 1'b0;
  logic [HASH_W-1:0] doc_min      = '0;
  bit                doc_has_word = 1'b0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Map the open word's hash and fold it into the document minimum
  function automatic void end_word();
    logic [HASH_W-1:0] mapped;
    if (!in_word) return;
    mapped = {1'b0, cfg_coef_a} * run_hash + {1'b0, cfg_offset_b};
    if (cfg_modulus != '0) mapped = mapped % cfg_modulus;
    if (!doc_has_word || mapped < doc_min) begin
      doc_min      = mapped;
      doc_has_word = 1'b1;
    end
    run_hash = HASH_SEED;
    in_word  = 1'b0;
  endfunction

  // Advance the document state by one accepted byte request
  function automatic void track_byte(doc_byte_t b);
    if (b.mode == MODE_CHAR) begin
      if (b.ch == CH_SPACE || b.ch == CH_NEWLINE) begin
        end_word();
      end else begin
        run_hash = run_hash * DJB_MULT + {{(HASH_W-CH_W){b.ch[CH_W-1]}}, b.ch};
        in_word  = 1'b1;
      end
    end else begin
      end_word();
      min_expected.push_back(doc_min_t'{min_hash:  doc_has_word ? doc_min : HASH_W'(0),
                                        empty_doc: !doc_has_word});
      run_hash     = HASH_SEED;
      in_word      = 1'b0;
      doc_min      = '0;
      doc_has_word = 1'b0;
    end
  endfunction

  function automatic void push_byte(logic mode, logic [CH_W-1:0] ch);
    byte_queue.push_back(doc_byte_t'{mode: mode, ch: ch});
    items_queued++;
  endfunction

  function automatic logic [CH_W-1:0] separator();
    return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_NEWLINE;
  endfunction

  // Half the time a small alphabet so that words repeat, else any non-separator byte
  function automatic logic [CH_W-1:0] word_char();
    logic [CH_W-1:0] c;
    if ($urandom_range(0, 1) != 0) return CH_W'("a" + $urandom_range(0, 3));
    do c = CH_W'($urandom_range(0, 255)); while (c == CH_SPACE || c == CH_NEWLINE);
    return c;
  endfunction

  // Queue one document: well-formed words most of the time, raw byte noise otherwise
  function automatic void queue_document();
    int n_words;
    int len;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 15);
      repeat (len) push_byte(MODE_CHAR, CH_W'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) push_byte(MODE_CHAR, separator());
      end
      n_words = $urandom_range(0, 6);
      for (int w = 0; w < n_words; w++) begin
        if (w > 0) repeat ($urandom_range(1, 3)) push_byte(MODE_CHAR, separator());
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        repeat (len) push_byte(MODE_CHAR, word_char());
      end
      if ($urandom_range(0, 1) != 0) push_byte(MODE_CHAR, separator());
    end
    push_byte(MODE_EOD, CH_W'($urandom_range(0, 255)));
  endfunction

  // APB write: setup cycle, then access until pready
  task automatic write_reg(reg_idx_e idx, logic [PDATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COEF_A:   cfg_coef_a   = value[COEF_W-1:0];
      REG_OFFSET_B: cfg_offset_b = value[COEF_W-1:0];
      REG_MODULUS:  cfg_modulus  = value;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [PDATA_W-1:0] a, logic [PDATA_W-1:0] b,
                            logic [PDATA_W-1:0] m);
    write_reg(REG_COEF_A, a);
    write_reg(REG_OFFSET_B, b);
    write_reg(REG_MODULUS, m);
  endtask

  // Hold until every request is sent and every minimum is back, then let the mapper settle
  task automatic drain();
    do @(negedge clk_i);
    while (byte_queue.size() != 0 || byte_req.valid || min_expected.size() != 0);
    repeat (MAP_LATENCY) @(posedge clk_i);
  endtask

  task automatic run_phase(int n_items);
    int target;
    @(negedge clk_i);
    target = items_queued + n_items;
    while (items_queued < target) queue_document();
    drain();
  endtask

  function automatic logic [PDATA_W-1:0] rand_modulus();
    case ($urandom_range(0, 4))
      0:       return PDATA_W'($urandom_range(1, 1000));
      1:       return PDATA_W'($urandom_range(1, 99839));
      2:       return '0;
      3:       return '1;
      default: return PDATA_W'($urandom());
    endcase
  endfunction

  // Send byte requests from the queue, with random gaps between them
  always @(posedge clk_i) begin
    doc_byte_t next;
    if (!rst_ni) begin
      byte_req.valid <= 1'b0;
    end else begin
      if (byte_req.valid && byte_req.ready) begin
        track_byte(doc_byte_t'{mode: byte_req.mode, ch: byte_req.ch});
      end
      if (!byte_req.valid || byte_req.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_req.valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          next = byte_queue.pop_front();
          byte_req.valid <= 1'b1;
          byte_req.mode  <= next.mode;
          byte_req.ch    <= next.ch;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
        end else begin
          byte_req.valid <= 1'b0;
        end
      end
    end
  end

  // Check each document minimum against the oldest prediction; stall at random
  always @(posedge clk_i) begin
    doc_min_t want;
    if (!rst_ni) begin
      min_req.ready <= 1'b0;
    end else begin
      if (min_req.valid && min_req.ready) begin
        mins_seen++;
        if (min_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual min_hash %h empty_doc %b",
                   $time, min_req.min_hash, min_req.empty_doc);
        end else begin
          want = min_expected.pop_front();
          if (min_req.min_hash !== want.min_hash) begin
            errors++;
            $display("%0t: min_hash expected %h actual %h",
                     $time, want.min_hash, min_req.min_hash);
          end
          if (min_req.empty_doc !== want.empty_doc) begin
            errors++;
            $display("%0t: empty_doc expected %b actual %b",
                     $time, want.empty_doc, min_req.empty_doc);
          end
        end
        // Hold off long enough that the block fills up and stalls its input
        if (!calm && (mins_seen == HOLD_AT_A || mins_seen == HOLD_AT_B)) begin
          recv_hold = LONG_HOLD;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        recv_hold = $urandom_range(1, 3);
      end
      min_req.ready <= (recv_hold == 0);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed documents at reset configuration
    // empty document
    push_byte(MODE_EOD, 8'hFF);
    // only separators, back to back
    push_byte(MODE_CHAR, CH_SPACE);
    push_byte(MODE_CHAR, CH_NEWLINE);
    push_byte(MODE_CHAR, CH_SPACE);
    push_byte(MODE_EOD, 8'h00);
    // word closed by the end of document
    push_byte(MODE_CHAR, 8'h61);
    push_byte(MODE_EOD, 8'h20);
    // byte extremes with sign extension, repeated separators, repeated word
    push_byte(MODE_CHAR, 8'h00);
    push_byte(MODE_CHAR, 8'hFF);
    push_byte(MODE_CHAR, 8'h80);
    push_byte(MODE_CHAR, 8'h7F);
    push_byte(MODE_CHAR, CH_SPACE);
    push_byte(MODE_CHAR, CH_SPACE);
    push_byte(MODE_CHAR, CH_NEWLINE);
    push_byte(MODE_CHAR, 8'h71);
    push_byte(MODE_CHAR, 8'h71);
    push_byte(MODE_CHAR, CH_SPACE);
    push_byte(MODE_CHAR, 8'h71);
    push_byte(MODE_CHAR, 8'h71);
    push_byte(MODE_CHAR, CH_NEWLINE);
    push_byte(MODE_EOD, 8'h0A);
    drain();

    // Largest coefficients and modulus
    set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    run_phase(120);
    // Smallest coefficients and modulus: every mapped word is zero
    set_config('0, '0, 32'd1);
    run_phase(60);
    // Zero modulus: the wrapped multiply-add is used as is
    set_config(PDATA_W'($urandom_range(0, 32'h7FFF_FFFF)),
               PDATA_W'($urandom_range(0, 32'h7FFF_FFFF)), '0);
    run_phase(120);

    // Random configurations
    while (items_queued < ITEM_TARGET - CALM_ITEMS) begin
      set_config(PDATA_W'($urandom_range(0, 32'h7FFF_FFFF)),
                 PDATA_W'($urandom_range(0, 32'h7FFF_FFFF)), rand_modulus());
      run_phase(PHASE_ITEMS);
    end

    // Closing stretch at back-to-back rate
    calm = 1'b1;
    set_config(PDATA_W'(COEF_A_RST), PDATA_W'(OFFSET_B_RST), MODULUS_RST);
    run_phase(CALM_ITEMS);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
